// ===== hdl/wlpe_pkg.sv =====
// Package for the word letter pattern encoder.
// Holds the transfer payload structs, the table write request and the letter helpers.
// No dependencies.
package wlpe_pkg;

  localparam int unsigned LetterCount = 26;
  localparam int unsigned IdxW        = $clog2(LetterCount);
  localparam int unsigned CodeW       = $clog2(LetterCount + 1);

  localparam logic [7:0] UpperA    = 8'd65;
  localparam logic [7:0] UpperZ    = 8'd90;
  localparam logic [7:0] LowerA    = 8'd97;
  localparam logic [7:0] LowerZ    = 8'd122;
  localparam logic [CodeW-1:0] CodeLimit = CodeW'(LetterCount);

  typedef struct packed {
    logic [7:0] char_in;
    logic       word_last;
  } in_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       out_last;
  } out_t;

  // Write request into the letter code table.
  typedef struct packed {
    logic             en;
    logic [IdxW-1:0]  idx;
    logic [CodeW-1:0] code;
  } code_wr_t;

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= UpperA) && (b <= UpperZ)) || ((b >= LowerA) && (b <= LowerZ));
  endfunction

  // Case-folded letter index, 0 for 'a' or 'A'. Non-letters map to 0.
  function automatic logic [IdxW-1:0] letter_idx(input logic [7:0] b);
    logic [7:0] off;
    off = 8'd0;
    if ((b >= LowerA) && (b <= LowerZ)) begin
      off = b - LowerA;
    end else if ((b >= UpperA) && (b <= UpperZ)) begin
      off = b - UpperA;
    end
    return off[IdxW-1:0];
  endfunction

endpackage

// ===== hdl/wlpe_code_ram.sv =====
// Letter code table: one write port and one read port with registered read data.
// Depends on wlpe_pkg.
module wlpe_code_ram import wlpe_pkg::*; (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [IdxW-1:0]  rd_idx_i,
  output logic [CodeW-1:0] rd_code_o,
  input  code_wr_t         wr_i
);

  logic [CodeW-1:0] mem_q [LetterCount];
  logic [CodeW-1:0] rd_code_q;

  // Read returns the old contents when the same entry is written in the same cycle.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.idx] <= wr_i.code;
    end
    if (rd_en_i) begin
      rd_code_q <= mem_q[rd_idx_i];
    end
  end

  assign rd_code_o = rd_code_q;

endmodule

// ===== hdl/word_letter_pattern_encoder.sv =====
// Word letter pattern encoder, top level.
// Depends on wlpe_pkg and wlpe_code_ram.
//
// The block takes a word one byte per transfer and returns one byte per transfer: letters
// (case ignored) are replaced by their pattern letter, the first distinct letter of the
// word becoming 'A', the next new one 'B', and so on, while every other byte passes
// through unchanged. The word_last flag is copied to out_last, and after that byte the
// seen-letter flags and the code counter clear, so the next byte starts a new word.
// Throughput is one byte per clock cycle while the output is not stalled. The edge that
// accepts an input transfer also launches the synchronous read of the letter code memory
// into the lookup stage; the item then moves on into the output register when that is
// free, and the output transfer is offered from there. Input is stalled only while
// both the lookup stage and the output register are full and the output is stalled.
// No configuration and no clearing pass after reset are needed, because the seen flags
// live in flip-flops.
module word_letter_pattern_encoder import wlpe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,

  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,

  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  // Handshake control.
  logic in_fire;
  logic out_free;
  logic s1_adv;

  // Lookup stage, holds the item whose code memory read is in flight.
  logic             s1_valid_q;
  in_t              s1_data_q;
  logic             s1_letter_q;
  logic [IdxW-1:0]  s1_idx_q;
  logic             fwd_hit_q;
  logic [CodeW-1:0] fwd_code_q;

  // Per-word state.
  logic [LetterCount-1:0] seen_q, seen_d;
  logic [CodeW-1:0]       next_code_q, next_code_d;

  // Output register.
  logic out_valid_q;
  out_t out_data_q;

  logic             in_letter;
  logic [IdxW-1:0]  in_idx;
  logic [CodeW-1:0] ram_code;
  logic             s1_seen;
  logic [CodeW-1:0] stored_code;
  logic [CodeW-1:0] s1_code;
  logic             new_letter;
  code_wr_t         code_wr;
  out_t             s1_result;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;

  assign in_letter = is_alpha(in_data_i.char_in);
  assign in_idx    = letter_idx(in_data_i.char_in);

  wlpe_code_ram u_code_ram (
    .clk_i     (clk_i),
    .rd_en_i   (in_fire),
    .rd_idx_i  (in_idx),
    .rd_code_o (ram_code),
    .wr_i      (code_wr)
  );

  // The memory read made at the edge that accepted this item misses a write made at that
  // same edge by the item ahead; the forwarded code covers that one case. Any later write
  // belongs to this item itself, since the table is only written when an item leaves.
  always_comb begin
    s1_seen     = s1_letter_q && seen_q[s1_idx_q];
    stored_code = fwd_hit_q ? fwd_code_q : ram_code;
    s1_code     = s1_seen ? stored_code : next_code_q;
    new_letter  = s1_letter_q && !s1_seen;

    code_wr.en   = s1_adv && new_letter;
    code_wr.idx  = s1_idx_q;
    code_wr.code = next_code_q;

    s1_result.char_out = s1_letter_q ? (UpperA + {{(8 - CodeW){1'b0}}, s1_code})
                                     : s1_data_q.char_in;
    s1_result.out_last = s1_data_q.word_last;
  end

  // Table update happens as the item leaves the lookup stage. The word end clears
  // everything after the flagged byte has been encoded with the current table.
  always_comb begin
    seen_d      = seen_q;
    next_code_d = next_code_q;
    if (s1_adv) begin
      if (s1_data_q.word_last) begin
        seen_d      = '0;
        next_code_d = '0;
      end else if (new_letter) begin
        seen_d[s1_idx_q] = 1'b1;
        if (next_code_q < CodeLimit) begin
          next_code_d = next_code_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      seen_q      <= '0;
      next_code_q <= '0;
    end else begin
      seen_q      <= seen_d;
      next_code_q <= next_code_d;
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_data_q   <= in_data_i;
      s1_letter_q <= in_letter;
      s1_idx_q    <= in_idx;
      fwd_hit_q   <= code_wr.en && (code_wr.idx == in_idx);
      fwd_code_q  <= code_wr.code;
    end
    if (s1_adv) begin
      out_data_q <= s1_result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== hdl/wlpe_checker.sv =====
// Port-level checker for the word letter pattern encoder, with its bind statement.
// Depends on wlpe_pkg.
module wlpe_checker import wlpe_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  logic out_fire;
  logic out_upper;
  logic word_start_q;

  assign out_fire  = out_valid_o && !out_stall_i;
  assign out_upper = (out_data_o.char_out >= UpperA) && (out_data_o.char_out <= UpperZ);

  // Set at the start of every word, cleared once the word has shown a letter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_start_q <= 1'b1;
    end else if (out_fire) begin
      if (out_data_o.out_last) begin
        word_start_q <= 1'b1;
      end else if (out_upper) begin
        word_start_q <= 1'b0;
      end
    end
  end

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_out_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

  a_no_lowercase_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !((out_data_o.char_out >= LowerA) && (out_data_o.char_out <= LowerZ)))
    else $error("lowercase letter left the encoder");

  a_first_letter_is_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && word_start_q && out_upper |-> out_data_o.char_out == UpperA)
    else $error("first letter of a word is not coded as A");

endmodule

bind word_letter_pattern_encoder wlpe_checker u_wlpe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ===== sim/testbench.sv =====
// Testbench for word_letter_pattern_encoder: directed, backpressure and random word traffic.
// Keeps its own letter pattern predictor and checks every output transfer against it.
// Depends on wlpe_pkg and the encoder RTL.
`timescale 1ns / 100ps

module testbench;
  import wlpe_pkg::*;

  logic clk_i;
  logic rst_ni;

  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;

  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  word_letter_pattern_encoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // 10 ns clock period.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Control shared between the test tasks and the idling processes.
  bit gaps_on = 1'b1;      // sender may pause between transfers
  bit stalls_on = 1'b1;    // receiver may stall in random bursts
  int hold_off_left = 0;   // receiver holds off for this many more cycles
  int sent_bytes = 0;
  int error_count = 0;
  int mismatch_count = 0;

  // Predicted output transfers, oldest first.
  out_t pattern_q[$];

  // Predictor state: which letters of the current word have a code, the codes,
  // and the code that the next new letter will get.
  logic             seen_flags [LetterCount];
  logic [CodeW-1:0] code_table [LetterCount];
  logic [CodeW-1:0] code_count;

  function automatic void clear_word_state();
    for (int k = 0; k < LetterCount; k++) begin
      seen_flags[k] = 1'b0;
      code_table[k] = '0;
    end
    code_count = '0;
  endfunction

  // Works out the output byte for one input byte and updates the word state.
  // The byte flagged last is encoded with the current table; the clear only
  // affects the byte after it.
  function automatic out_t pattern_encode(in_t item);
    out_t        r;
    logic [7:0]  b;
    int unsigned k;
    b          = item.char_in;
    r.char_out = b;
    r.out_last = item.word_last;
    if (((b >= UpperA) && (b <= UpperZ)) || ((b >= LowerA) && (b <= LowerZ))) begin
      k = (b >= LowerA) ? int'(b - LowerA) : int'(b - UpperA);
      if (seen_flags[k]) begin
        r.char_out = UpperA + 8'(code_table[k]);
      end else begin
        r.char_out    = UpperA + 8'(code_count);
        seen_flags[k] = 1'b1;
        code_table[k] = code_count;
        // A word has at most 26 distinct letters; the counter stops at 26.
        if (code_count < CodeLimit) begin
          code_count = code_count + 1'b1;
        end
      end
    end
    if (item.word_last) begin
      clear_word_state();
    end
    return r;
  endfunction

  initial begin
    clear_word_state();
  end

  // Both ports are sampled at the rising edge, before any of the nonblocking
  // updates of that edge, so the values seen are the ones the transfer used.
  // Input transfers feed the predictor; output transfers are compared with the
  // oldest prediction, field by field.
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        pattern_q = {pattern_q, pattern_encode(in_data_i)};
      end
      if (out_valid_o && !out_stall_i) begin
        if (pattern_q.size() == 0) begin
          error_count++;
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: unexpected output transfer char_out=%02h out_last=%0b",
                     out_data_o.char_out, out_data_o.out_last);
          end
        end else begin
          want = pattern_q.pop_front();
          if (want.char_out !== out_data_o.char_out) begin
            error_count++;
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("mismatch: char_out expected %02h actual %02h",
                       want.char_out, out_data_o.char_out);
            end
          end
          if (want.out_last !== out_data_o.out_last) begin
            error_count++;
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("mismatch: out_last expected %0b actual %0b",
                       want.out_last, out_data_o.out_last);
            end
          end
        end
      end
    end
  end

  // Receiver side. A requested hold-off wins over everything else; otherwise
  // the stall is drawn anew in random bursts, about a third of them stalled, unless
  // idling is switched off for the end of the run.
  initial begin
    int burst_left;
    bit burst_stall;
    burst_left  = 0;
    burst_stall = 1'b0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_left > 0) begin
        out_stall_i <= 1'b1;
        hold_off_left--;
      end else if (!stalls_on) begin
        out_stall_i <= 1'b0;
      end else begin
        if (burst_left == 0) begin
          burst_left  = $urandom_range(1, 16);
          burst_stall = ($urandom_range(0, 2) == 0);
        end
        out_stall_i <= burst_stall;
        burst_left--;
      end
    end
  end

  // Offers one byte and returns at the edge where the transfer happens.
  // A pause, when one is drawn, comes before the byte; valid only drops for
  // a pause, so it is never lowered and raised in the same time step.
  task automatic offer_byte(input logic [7:0] ch, input logic last);
    int gap;
    if (gaps_on && ($urandom_range(0, 3) == 0)) begin
      gap = $urandom_range(1, 16);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i          <= 1'b1;
    in_data_i.char_in   <= ch;
    in_data_i.word_last <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_bytes++;
  endtask

  // Sends a string as one word, last flag on its final byte.
  task automatic offer_word(input string s);
    for (int i = 0; i < s.len(); i++) begin
      offer_byte(s[i], i == s.len() - 1);
    end
  endtask

  // Letter range edges, bytes just outside them, high bytes, case folding
  // and the clear that follows a flagged last byte.
  task automatic test_directed();
    offer_word("aAbB");
    offer_byte(8'h00, 1'b0);
    offer_byte(8'hFF, 1'b0);
    offer_byte(8'h40, 1'b0);
    offer_byte(8'h5B, 1'b0);
    offer_byte(8'h60, 1'b0);
    offer_byte(8'h7B, 1'b0);
    offer_byte(8'h7F, 1'b0);
    offer_byte(8'h80, 1'b1);
    offer_word("zZa");
    offer_word("Q");
    offer_word("q");
    offer_word("xy");
    offer_word("y");
    offer_byte(8'h20, 1'b1);
  endtask

  // Every letter once, so the codes run up to 'Z' and the counter reaches
  // its bound, then repeats that must reuse their codes.
  task automatic test_full_alphabet();
    for (int k = 25; k >= 0; k--) begin
      offer_byte((k % 2) ? (LowerA + 8'(k)) : (UpperA + 8'(k)), 1'b0);
    end
    offer_byte("M", 1'b0);
    offer_byte("m", 1'b0);
    offer_byte("a", 1'b1);
    offer_word("k");
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering bytes back to back, so the block fills and stalls its input.
  // Valid drops for the setup cycle so the last byte is not offered twice.
  task automatic test_backpressure();
    gaps_on = 1'b0;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    hold_off_left = 120;
    for (int i = 0; i < 40; i++) begin
      offer_byte(LowerA + 8'($urandom_range(0, 5)), ($urandom_range(0, 7) == 0));
    end
    gaps_on = 1'b1;
  endtask

  // Mostly well-formed words with random content: small alphabets give many
  // repeats, some long words use up the whole alphabet, and a few non-letter
  // bytes are mixed in. The rest is noise with random last flags.
  task automatic offer_random_word();
    int len;
    int span;
    logic [7:0] ch;
    if ($urandom_range(0, 9) == 0) begin
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        offer_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end else begin
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(27, 60) : $urandom_range(1, 10);
      span = ($urandom_range(0, 1) == 0) ? $urandom_range(2, 8) : 26;
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 7) == 0) begin
          ch = 8'($urandom_range(0, 255));
        end else begin
          ch = (($urandom_range(0, 1) == 0) ? LowerA : UpperA) + 8'($urandom_range(0, span - 1));
        end
        offer_byte(ch, i == len - 1);
      end
    end
  endtask

  task automatic test_random_words(input int target);
    while (sent_bytes < target) offer_random_word();
  endtask

  // Last part of the run with no idling on either side.
  task automatic test_quiet_tail(input int target);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    while (sent_bytes < target) offer_random_word();
  endtask

  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_full_alphabet();
    test_backpressure();
    test_random_words(sent_bytes + 780);
    test_quiet_tail(sent_bytes + 60);
    in_valid_i <= 1'b0;

    // Drain what is still in flight, then let the two-stage pipeline run on
    // long enough to show any stray output.
    while (pattern_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // A correct run ends well before this watchdog fires.
  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

endmodule
